// File: design/csd_pkg.sv
// Package for the Cesaro spectral damping unit.
// Holds the sizes, register indexes and the controller/datapath structs.
// No dependencies.
package csd_pkg;

   // field sizes
   localparam int MAX_TRUNC   = 1023;
   localparam int COEFF_WIDTH = 32;
   localparam int DEG_W       = $clog2(MAX_TRUNC + 1);
   localparam int CFG_DEG_W   = 10;
   localparam int ORDER_W     = 16;

   // Q1.30 factor
   localparam int FACT_W = 31;
   localparam int FRAC_W = 30;
   localparam logic [FACT_W-1:0] Q30_ONE = FACT_W'(64'd1 << FRAC_W);

   // factor recurrence: a = T - n + 1, a8 = a in Q11.8, den = a8 + k
   localparam int A_W    = DEG_W + 1;
   localparam int A8_W   = A_W + 8;
   localparam int DEN_W  = ((A8_W > ORDER_W) ? A8_W : ORDER_W) + 1;
   localparam int NUM_W  = FACT_W + A8_W;
   localparam int STEP_W = $clog2(FACT_W + 1);

   // coefficient by factor product
   localparam int PROD_W = COEFF_WIDTH + FACT_W + 1;

   // register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_TRUNCATION    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF_DEGREE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING_ORDER = 2'd2;

   localparam logic [CFG_DEG_W-1:0] TRUNCATION_RESET = 10'd1023;
   localparam logic [CFG_DEG_W-1:0] CUTOFF_RESET     = 10'd1;
   localparam logic [ORDER_W-1:0]   ORDER_RESET      = 16'd512;

   // controller to datapath
   typedef struct packed {
      logic accept;     // take the input beat, advance the counters
      logic prod_load;  // form the recurrence numerator and divisor
      logic div_start;  // launch the divider
      logic commit;     // load the result register; on the m=0 row, store the factor
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_div;   // pending item is on the m=0 row at or above the cutoff
      logic div_done;
      logic out_free;
   } sts_type;

endpackage

// File: design/csd_if.sv
// Stream interfaces for the Cesaro spectral damping unit.
// Depends on csd_pkg.
interface csd_req_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [csd_pkg::COEFF_WIDTH-1:0]   coeff_re;
   logic signed [csd_pkg::COEFF_WIDTH-1:0]   coeff_im;

   modport source (output valid, output coeff_re, output coeff_im, input ready);
   modport sink   (input valid, input coeff_re, input coeff_im, output ready);
endinterface

interface csd_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [csd_pkg::COEFF_WIDTH-1:0]   damped_re;
   logic signed [csd_pkg::COEFF_WIDTH-1:0]   damped_im;
   logic                                     field_last;

   modport source (output valid, output damped_re, output damped_im, output field_last,
                   input ready);
   modport sink   (input valid, input damped_re, input damped_im, input field_last,
                   output ready);
endinterface

// File: design/cesaro_spectral_damping_unit.sv
// Cesaro spectral damping unit. Spherical-harmonic coefficients arrive one beat at a
// time, m from 0 to the truncation and n from m to the truncation within each m; both
// parts are scaled by the Cesaro factor of degree n and truncated toward minus infinity.
// A coefficient is normally captured, then multiplied into the result register.
// On the m=0 row, degrees at or above the cutoff first pass through the
// one-bit-a-cycle divider that forms the factor (product, launch, 31 quotient bits,
// then multiply); all m=0 factors are stored in a 1024-entry table and read back for
// every later row. The result register lets the next beat be taken while a result waits.
// Registers may be written only while the unit is idle; a write that leaves the position
// beyond the truncation restarts the field at m=n=0.
// Depends on csd_pkg, csd_if, csd_ctrl, csd_dpath, csd_div.
module cesaro_spectral_damping_unit (
   input  logic                                clock,
   input  logic                                reset,
   csd_req_if.sink                             req_chan,
   csd_rsp_if.source                           rsp_chan,
   input  logic                                csr_we,
   input  logic [csd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [csd_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   csd_pkg::cmd_type cmd;
   csd_pkg::sts_type sts;

   csd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   csd_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .coeff_re   (req_chan.coeff_re),
      .coeff_im   (req_chan.coeff_im),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .damped_re  (rsp_chan.damped_re),
      .damped_im  (rsp_chan.damped_im),
      .field_last (rsp_chan.field_last)
   );

endmodule

// File: design/csd_div.sv
// Restoring divider for the Cesaro factor recurrence, one quotient bit a cycle.
// Depends on csd_pkg.
module csd_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [csd_pkg::NUM_W-1:0]     num,
   input  logic [csd_pkg::DEN_W-1:0]     den,
   output logic                          done,
   output logic [csd_pkg::FACT_W-1:0]    quot
);

   logic [csd_pkg::DEN_W-1:0]   rem_ff, rem_in;
   logic [csd_pkg::FACT_W-1:0]  quo_ff, quo_in;
   logic [csd_pkg::DEN_W-1:0]   den_ff;
   logic [csd_pkg::STEP_W-1:0]  cnt_ff;
   logic                        busy_ff, done_ff;
   logic [csd_pkg::DEN_W:0]     trial;
   logic                        fits;

   // one restoring step: bring down the next dividend bit, subtract if it fits
   always_comb begin
      trial  = {rem_ff, quo_ff[csd_pkg::FACT_W-1]};
      fits   = (trial >= {1'b0, den_ff});
      rem_in = fits ? csd_pkg::DEN_W'(trial - {1'b0, den_ff}) : csd_pkg::DEN_W'(trial);
      quo_in = {quo_ff[csd_pkg::FACT_W-2:0], fits};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= csd_pkg::STEP_W'(csd_pkg::FACT_W - 1);
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end else begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   // operands; quotient fits FACT_W bits, so the top of the numerator is below den
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= csd_pkg::DEN_W'(num[csd_pkg::NUM_W-1:csd_pkg::FACT_W]);
         quo_ff <= num[csd_pkg::FACT_W-1:0];
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

// File: design/csd_ctrl.sv
// Controller for the Cesaro spectral damping unit: sequences one beat at a time.
// Depends on csd_pkg.
module csd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  csd_pkg::sts_type    sts,
   output csd_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROD,
      ST_DIV_GO,
      ST_DIV,
      ST_MUL
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   // commands
   always_comb begin
      cmd           = '0;
      cmd.accept    = ready_ff && req_valid;
      cmd.prod_load = (state_ff == ST_PROD);
      cmd.div_start = (state_ff == ST_DIV_GO);
      cmd.commit    = (state_ff == ST_MUL) && sts.out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) state_in = sts.need_div ? ST_PROD : ST_MUL;
         end
         ST_PROD:   state_in = ST_DIV_GO;
         ST_DIV_GO: state_in = ST_DIV;
         ST_DIV: begin
            if (sts.div_done) state_in = ST_MUL;
         end
         ST_MUL: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
      ready_in = (state_in == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

// File: design/csd_dpath.sv
// Datapath for the Cesaro spectral damping unit: registers, degree counters,
// factor table, recurrence divider and output multipliers. Depends on csd_pkg, csd_div.
module csd_dpath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  csd_pkg::cmd_type                       cmd,
   output csd_pkg::sts_type                       sts,
   input  logic signed [csd_pkg::COEFF_WIDTH-1:0] coeff_re,
   input  logic signed [csd_pkg::COEFF_WIDTH-1:0] coeff_im,
   input  logic                                   csr_we,
   input  logic [csd_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [csd_pkg::CSR_DATA_W-1:0]         csr_wdata,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output logic signed [csd_pkg::COEFF_WIDTH-1:0] damped_re,
   output logic signed [csd_pkg::COEFF_WIDTH-1:0] damped_im,
   output logic                                   field_last
);

   // configuration
   logic [csd_pkg::CFG_DEG_W-1:0] truncation_ff, cutoff_degree_ff;
   logic [csd_pkg::ORDER_W-1:0]   damping_order_ff;

   // walk over the field
   logic [csd_pkg::DEG_W-1:0] order_m_ff, degree_n_ff;
   logic [csd_pkg::DEG_W-1:0] order_m_in, degree_n_in;
   logic [csd_pkg::DEG_W-1:0] t_eff, m_eff, n_eff;
   logic [csd_pkg::DEG_W:0]   m_inc;
   logic                      damp_pre;

   // per-item registers
   logic signed [csd_pkg::COEFF_WIDTH-1:0] coeff_re_ff, coeff_im_ff;
   logic [csd_pkg::DEG_W-1:0]              n_item_ff;
   logic                                   row0_ff, damp_ff, last_ff;

   // factors
   logic [csd_pkg::FACT_W-1:0] fact_mem [0:csd_pkg::MAX_TRUNC];
   logic [csd_pkg::FACT_W-1:0] fact_rd_ff;
   logic [csd_pkg::FACT_W-1:0] prev_factor_ff;
   logic [csd_pkg::FACT_W-1:0] prev_sel, factor, div_quot;
   logic [csd_pkg::A_W-1:0]    a_val;
   logic [csd_pkg::A8_W-1:0]   a8;
   logic [csd_pkg::NUM_W-1:0]  num_ff;
   logic [csd_pkg::DEN_W-1:0]  den_ff;
   logic                       div_done;

   // products and result register
   logic signed [csd_pkg::FACT_W:0]         fact_s;
   logic signed [csd_pkg::PROD_W-1:0]       prod_re, prod_im;
   logic signed [csd_pkg::COEFF_WIDTH-1:0]  rsp_re_ff, rsp_im_ff;
   logic                                    rsp_last_ff, rsp_valid_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         truncation_ff    <= csd_pkg::TRUNCATION_RESET;
         cutoff_degree_ff <= csd_pkg::CUTOFF_RESET;
         damping_order_ff <= csd_pkg::ORDER_RESET;
      end else if (csr_we) begin
         case (csr_index)
            csd_pkg::CSR_TRUNCATION:    truncation_ff    <= csr_wdata[csd_pkg::CFG_DEG_W-1:0];
            csd_pkg::CSR_CUTOFF_DEGREE: cutoff_degree_ff <= csr_wdata[csd_pkg::CFG_DEG_W-1:0];
            csd_pkg::CSR_DAMPING_ORDER: damping_order_ff <= csr_wdata[csd_pkg::ORDER_W-1:0];
            default: ;
         endcase
      end
   end

   // position of the pending beat, restarting the field if the counters are stale
   always_comb begin
      t_eff = csd_pkg::DEG_W'((int'(truncation_ff) > csd_pkg::MAX_TRUNC) ?
                              csd_pkg::MAX_TRUNC : int'(truncation_ff));
      if ((order_m_ff > t_eff) || (degree_n_ff > t_eff) || (degree_n_ff < order_m_ff)) begin
         m_eff = '0;
         n_eff = '0;
      end else begin
         m_eff = order_m_ff;
         n_eff = degree_n_ff;
      end
      damp_pre = (int'(n_eff) >= int'(cutoff_degree_ff));

      // next position: end of a row moves to the diagonal of the next m
      m_inc       = {1'b0, m_eff} + 1'b1;
      order_m_in  = m_eff;
      degree_n_in = n_eff + 1'b1;
      if (n_eff >= t_eff) begin
         if (m_inc > {1'b0, t_eff}) begin
            order_m_in  = '0;
            degree_n_in = '0;
         end else begin
            order_m_in  = m_inc[csd_pkg::DEG_W-1:0];
            degree_n_in = m_inc[csd_pkg::DEG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_m_ff  <= '0;
         degree_n_ff <= '0;
      end else if (cmd.accept) begin
         order_m_ff  <= order_m_in;
         degree_n_ff <= degree_n_in;
      end
   end

   // capture the beat
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         coeff_re_ff <= coeff_re;
         coeff_im_ff <= coeff_im;
         n_item_ff   <= n_eff;
         row0_ff     <= (m_eff == '0);
         damp_ff     <= damp_pre;
         last_ff     <= (m_eff == t_eff) && (n_eff == t_eff);
      end
   end

   // recurrence operands: prev * a8 over a8 + k
   always_comb begin
      prev_sel = (n_item_ff == '0) ? csd_pkg::Q30_ONE : prev_factor_ff;
      a_val    = csd_pkg::A_W'({1'b0, t_eff}) - csd_pkg::A_W'({1'b0, n_item_ff}) + 1'b1;
      a8       = {a_val, 8'b0};
   end

   always_ff @(posedge clock) begin
      if (cmd.prod_load) begin
         num_ff <= prev_sel * a8;
         den_ff <= csd_pkg::DEN_W'(a8) + csd_pkg::DEN_W'(damping_order_ff);
      end
   end

   csd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // factor of this degree
   always_comb begin
      if (row0_ff) factor = damp_ff ? div_quot : csd_pkg::Q30_ONE;
      else         factor = fact_rd_ff;
   end

   // factor table: written on the m=0 row, read back at accept for later rows
   always_ff @(posedge clock) begin
      if (cmd.commit && row0_ff) fact_mem[n_item_ff] <= factor;
      if (cmd.accept)            fact_rd_ff <= fact_mem[n_eff];
   end

   always_ff @(posedge clock) begin
      if (reset)                          prev_factor_ff <= csd_pkg::Q30_ONE;
      else if (cmd.commit && row0_ff)     prev_factor_ff <= factor;
   end

   // scale both parts; arithmetic shift gives floor
   always_comb begin
      fact_s  = $signed({1'b0, factor});
      prod_re = coeff_re_ff * fact_s;
      prod_im = coeff_im_ff * fact_s;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset)                  rsp_valid_ff <= 1'b0;
      else if (cmd.commit)        rsp_valid_ff <= 1'b1;
      else if (rsp_ready)         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_re_ff   <= prod_re[csd_pkg::FRAC_W +: csd_pkg::COEFF_WIDTH];
         rsp_im_ff   <= prod_im[csd_pkg::FRAC_W +: csd_pkg::COEFF_WIDTH];
         rsp_last_ff <= last_ff;
      end
   end

   always_comb begin
      sts          = '0;
      sts.need_div = (m_eff == '0) && damp_pre;
      sts.div_done = div_done;
      sts.out_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign damped_re  = rsp_re_ff;
   assign damped_im  = rsp_im_ff;
   assign field_last = rsp_last_ff;

endmodule

// File: design/csd_checker.sv
// Port-level checks for the Cesaro spectral damping unit, bound to the top level.
// Depends on csd_pkg and cesaro_spectral_damping_unit.
module csd_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [csd_pkg::COEFF_WIDTH-1:0] damped_re,
   input logic signed [csd_pkg::COEFF_WIDTH-1:0] damped_im,
   input logic                                   field_last
);

   // after reset: nothing pending, ready for a beat
   a_reset_clean: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("unit not idle after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(damped_re) && $stable(damped_im) && $stable(field_last)))
      else $error("stalled result changed");

   // one beat at a time: ready drops after each accepted beat
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("beat taken while the previous one is in work");

   // a new result is only produced while the input side is closed
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without an item in work");

endmodule

bind cesaro_spectral_damping_unit csd_checker u_csd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .damped_re  (rsp_chan.damped_re),
   .damped_im  (rsp_chan.damped_im),
   .field_last (rsp_chan.field_last)
);

// File: tb/tb.sv
// Self-checking testbench for the Cesaro spectral damping unit.
// Predicts every result beat from its own factor recurrence and compares it in order.
// Depends on csd_pkg, csd_if and cesaro_spectral_damping_unit.
`timescale 1ns / 100ps

module tb;

   typedef struct {
      logic signed [csd_pkg::COEFF_WIDTH-1:0] re;
      logic signed [csd_pkg::COEFF_WIDTH-1:0] im;
      logic                                   last;
   } damped_type;

   logic                           clock;
   logic                           reset;
   logic                           csr_we;
   logic [csd_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [csd_pkg::CSR_DATA_W-1:0] csr_wdata;

   csd_req_if req_chan ();
   csd_rsp_if rsp_chan ();

   cesaro_spectral_damping_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state: register copies, factor table, recurrence and counters
   logic [csd_pkg::CFG_DEG_W-1:0] trunc_cfg;
   logic [csd_pkg::CFG_DEG_W-1:0] cutoff_cfg;
   logic [csd_pkg::ORDER_W-1:0]   order_cfg;
   logic [csd_pkg::FACT_W-1:0]    fct_table [0:csd_pkg::MAX_TRUNC];
   logic [csd_pkg::FACT_W-1:0]    prev_fct;
   int unsigned                   row_m;
   int unsigned                   deg_n;

   damped_type  damped_q [$];
   damped_type  want;
   int unsigned mismatches;
   bit          sender_eager;
   bit          sink_eager;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog
   initial begin
      #(20_000_000);
      $display("tb: errors");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("tb: mismatch at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   // part * f / 2^30, floored
   function automatic logic signed [csd_pkg::COEFF_WIDTH-1:0] scale_part(
      input logic signed [csd_pkg::COEFF_WIDTH-1:0] x, input logic [csd_pkg::FACT_W-1:0] f);
      longint prod;
      prod = longint'(x) * longint'(f);
      return csd_pkg::COEFF_WIDTH'(prod >>> csd_pkg::FRAC_W);
   endfunction

   // work out the damped coefficient for one accepted beat and queue it
   task automatic predict_damped(input logic signed [csd_pkg::COEFF_WIDTH-1:0] re,
                                 input logic signed [csd_pkg::COEFF_WIDTH-1:0] im);
      int unsigned                t, m, n;
      logic [csd_pkg::FACT_W-1:0] f, prev;
      longint unsigned            a8, den;
      damped_type                 res;
      t = trunc_cfg;
      m = row_m;
      n = deg_n;
      // counters left beyond the truncation by a register write: restart the field
      if (m > t || n > t || n < m) begin
         m = 0;
         n = 0;
      end
      if (m == 0) begin
         prev = (n == 0) ? csd_pkg::Q30_ONE : prev_fct;
         if (n < cutoff_cfg) begin
            f = csd_pkg::Q30_ONE;
         end else begin
            a8  = longint'(t - n + 1) << 8;
            den = a8 + longint'(order_cfg);
            f   = csd_pkg::FACT_W'((longint'(prev) * a8) / den);
         end
         fct_table[n] = f;
         prev_fct     = f;
      end else begin
         f = fct_table[n];
      end
      res.re   = scale_part(re, f);
      res.im   = scale_part(im, f);
      res.last = (m == t && n == t);
      damped_q.push_back(res);
      // step to the next degree, next order or next field
      if (n >= t) begin
         m = m + 1;
         n = m;
         if (m > t) begin
            m = 0;
            n = 0;
         end
      end else begin
         n = n + 1;
      end
      row_m = m;
      deg_n = n;
   endtask

   // one coefficient beat, after a random gap
   task automatic send_coeff(input logic [csd_pkg::COEFF_WIDTH-1:0] re,
                             input logic [csd_pkg::COEFF_WIDTH-1:0] im);
      int unsigned gap;
      gap = sender_eager ? 0 : $urandom_range(0, 17);
      @(negedge clock);
      if (gap != 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid    = 1'b1;
      req_chan.coeff_re = re;
      req_chan.coeff_im = im;
      do @(posedge clock); while (!req_chan.ready);
      predict_damped(re, im);
   endtask

   // stop sending and hold off until every expected beat has come back
   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (damped_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [csd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [csd_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         csd_pkg::CSR_TRUNCATION:    trunc_cfg  = data[csd_pkg::CFG_DEG_W-1:0];
         csd_pkg::CSR_CUTOFF_DEGREE: cutoff_cfg = data[csd_pkg::CFG_DEG_W-1:0];
         csd_pkg::CSR_DAMPING_ORDER: order_cfg  = data[csd_pkg::ORDER_W-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [csd_pkg::COEFF_WIDTH-1:0] corner_coeff(input int unsigned i);
      case (i % 6)
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         4:       return 32'h0000_0001;
         default: return 32'h4000_0000;
      endcase
   endfunction

   function automatic logic [csd_pkg::COEFF_WIDTH-1:0] pick_coeff();
      if ($urandom_range(0, 7) == 0)
         return corner_coeff($urandom_range(0, 5));
      return $urandom;
   endfunction

   // reset values: a few degrees of the m=0 row at full truncation, left unfinished
   task automatic test_reset_defaults();
      for (int unsigned i = 0; i < 8; i++)
         send_coeff(corner_coeff(i), corner_coeff(i + 3));
   endtask

   // field of truncation 1; the truncation write also restarts the unfinished field above
   task automatic test_minimal_field();
      wait_drained();
      write_reg(csd_pkg::CSR_TRUNCATION, 16'd1);
      write_reg(csd_pkg::CSR_CUTOFF_DEGREE, 16'd1);
      write_reg(csd_pkg::CSR_DAMPING_ORDER, 16'd512);
      for (int unsigned i = 0; i < 3; i++)
         send_coeff(corner_coeff(i), corner_coeff(i + 1));
   endtask

   // cutoff of zero damps degree 0 too; largest order
   task automatic test_cutoff_zero();
      wait_drained();
      write_reg(csd_pkg::CSR_TRUNCATION, 16'd2);
      write_reg(csd_pkg::CSR_CUTOFF_DEGREE, 16'd0);
      write_reg(csd_pkg::CSR_DAMPING_ORDER, 16'hFFFF);
      for (int unsigned i = 0; i < 6; i++)
         send_coeff(corner_coeff(i + 2), corner_coeff(i + 4));
   endtask

   // cutoff beyond the truncation: all factors one; order of zero
   task automatic test_cutoff_above();
      wait_drained();
      write_reg(csd_pkg::CSR_CUTOFF_DEGREE, 16'd1023);
      write_reg(csd_pkg::CSR_DAMPING_ORDER, 16'd0);
      for (int unsigned i = 0; i < 6; i++)
         send_coeff(corner_coeff(i + 5), corner_coeff(i));
   endtask

   // full truncation, m=0 row up to degree 1022 so a values down to 2 are reached
   task automatic test_deep_truncation();
      wait_drained();
      write_reg(csd_pkg::CSR_TRUNCATION, 16'd1023);
      write_reg(csd_pkg::CSR_CUTOFF_DEGREE, 16'd1000);
      write_reg(csd_pkg::CSR_DAMPING_ORDER, 16'($urandom_range(1, 1024)));
      sender_eager = 1'b1;
      for (int unsigned i = 0; i < 1023; i++) begin
         if (i == 990)
            sender_eager = 1'b0;
         send_coeff(pick_coeff(), pick_coeff());
      end
   endtask

   // random settings per field, mostly complete fields, some cut short on the m=0 row
   task automatic test_random_fields();
      int unsigned                   t, beats, abort_len, sent;
      logic [csd_pkg::CFG_DEG_W-1:0] cut;
      logic [csd_pkg::ORDER_W-1:0]   ord;
      sent      = 0;
      abort_len = 0;
      while (sent < 750) begin
         wait_drained();
         sender_eager = ($urandom_range(0, 3) == 0);
         sink_eager   = ($urandom_range(0, 4) == 0);
         // a cut-short row needs a truncation no higher than its last degree to restart
         if (abort_len != 0) begin
            t = $urandom_range(1, abort_len - 1);
         end else begin
            case ($urandom_range(0, 19))
               0:       t = $urandom_range(17, 30);
               1, 2, 3: t = $urandom_range(9, 16);
               default: t = $urandom_range(1, 8);
            endcase
         end
         write_reg(csd_pkg::CSR_TRUNCATION, {6'($urandom), csd_pkg::CFG_DEG_W'(t)});
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 5))
               0:       cut = '0;
               1:       cut = csd_pkg::CFG_DEG_W'(t + 1);
               2:       cut = '1;
               3:       cut = csd_pkg::CFG_DEG_W'($urandom);
               default: cut = csd_pkg::CFG_DEG_W'($urandom_range(1, t));
            endcase
            write_reg(csd_pkg::CSR_CUTOFF_DEGREE, {6'($urandom), cut});
         end
         if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 5))
               0:       ord = '0;
               1:       ord = '1;
               2:       ord = csd_pkg::ORDER_W'($urandom);
               default: ord = csd_pkg::ORDER_W'($urandom_range(0, 2048));
            endcase
            write_reg(csd_pkg::CSR_DAMPING_ORDER, ord);
         end
         beats     = (t + 1) * (t + 2) / 2;
         abort_len = 0;
         if (t >= 2 && $urandom_range(0, 7) == 0) begin
            abort_len = $urandom_range(2, t);
            beats     = abort_len;
         end
         repeat (beats) begin
            if ($urandom_range(0, 63) == 0)
               wait_drained();
            send_coeff(pick_coeff(), pick_coeff());
         end
         sent += beats;
      end
   endtask

   // result sink: random stall before each beat
   initial begin
      int unsigned stall;
      rsp_chan.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = sink_eager ? 0 : $urandom_range(0, 17);
         @(negedge clock);
         if (stall != 0) begin
            rsp_chan.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (damped_q.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            want = damped_q.pop_front();
            if (rsp_chan.damped_re !== want.re)
               report_mismatch($sformatf("damped_re %h, expected %h",
                                         rsp_chan.damped_re, want.re));
            if (rsp_chan.damped_im !== want.im)
               report_mismatch($sformatf("damped_im %h, expected %h",
                                         rsp_chan.damped_im, want.im));
            if (rsp_chan.field_last !== want.last)
               report_mismatch($sformatf("field_last %b, expected %b",
                                         rsp_chan.field_last, want.last));
         end
      end
   end

   // main sequence
   initial begin
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_chan.valid    = 1'b0;
      req_chan.coeff_re = '0;
      req_chan.coeff_im = '0;
      mismatches        = 0;
      sender_eager      = 1'b0;
      sink_eager        = 1'b0;
      trunc_cfg         = csd_pkg::TRUNCATION_RESET;
      cutoff_cfg        = csd_pkg::CUTOFF_RESET;
      order_cfg         = csd_pkg::ORDER_RESET;
      prev_fct          = csd_pkg::Q30_ONE;
      row_m             = 0;
      deg_n             = 0;
      for (int i = 0; i <= csd_pkg::MAX_TRUNC; i++)
         fct_table[i] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_minimal_field();
      test_cutoff_zero();
      test_cutoff_above();
      test_deep_truncation();
      test_random_fields();

      wait_drained();
      repeat (64) @(posedge clock);
      if (mismatches == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
